// File: rtl/lms_pkg.sv
// ----------------------------------------------------------------------------
// lms_pkg
// shared types, constants and helpers of the li chao minimum line store
// ----------------------------------------------------------------------------
package lms_pkg;

  localparam int unsigned DOMAIN_BITS = 10;
  localparam int unsigned LEVELS      = DOMAIN_BITS + 1;
  localparam int unsigned LVL_W       = $clog2(DOMAIN_BITS + 2);
  localparam int unsigned ARG_W       = ((DOMAIN_BITS > 10) ? DOMAIN_BITS : 10) + 2;
  localparam int unsigned VAL_W       = ((33 + DOMAIN_BITS > 48) ? 33 + DOMAIN_BITS : 48) + 1;

  localparam logic [DOMAIN_BITS-1:0] DOMAIN_MAX = {DOMAIN_BITS{1'b1}};
  localparam logic [LVL_W-1:0]       NO_LVL     = LVL_W'(DOMAIN_BITS + 1);
  localparam logic signed [60:0]     EMPTY_VALUE = 61'sd1000000000000000000;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_SEG   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // one stored node
  typedef struct packed {
    logic               used;
    logic signed [31:0] slope;
    logic signed [47:0] icpt;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  // work token travelling down the row of level cells
  typedef struct packed {
    logic                     valid;
    logic                     tail;
    logic                     query;
    logic                     armed;
    logic [LVL_W-1:0]         lvl;
    logic [DOMAIN_BITS-1:0]   off;
    logic [DOMAIN_BITS-1:0]   lo;
    logic [DOMAIN_BITS-1:0]   hi;
    logic [DOMAIN_BITS-1:0]   qx;
    logic signed [31:0]       slope;
    logic signed [47:0]       icpt;
    logic signed [VAL_W-1:0]  best;
    logic                     found;
  } tok_t;

  // write port of one level memory
  typedef struct packed {
    logic                   we;
    logic [DOMAIN_BITS-1:0] addr;
    node_t                  data;
  } ram_wr_t;

  // slope * x + intercept at full precision
  function automatic logic signed [VAL_W-1:0] line_at(
    input logic signed [31:0]     k,
    input logic signed [47:0]     b,
    input logic [DOMAIN_BITS-1:0] x
  );
    logic signed [VAL_W-1:0] xs;
    xs = $signed(VAL_W'(x));
    return VAL_W'(k) * xs + VAL_W'(b);
  endfunction

endpackage

// File: rtl/lms_ram.sv
// ----------------------------------------------------------------------------
// lms_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/lms_cell.sv
// ----------------------------------------------------------------------------
// lms_cell
// one tree level: reads its node, compares lines, writes back, hands on
// ----------------------------------------------------------------------------
module lms_cell
  import lms_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [LVL_W-1:0]       level_i,
  input  tok_t                   tok_i,
  output tok_t                   tok_o,
  output logic [DOMAIN_BITS-1:0] raddr_o,
  input  node_t                  rdata_i,
  output ram_wr_t                wr_o
);

  tok_t                    tok1_q, tok1_d;
  tok_t                    tok2_q, tok3_d;
  node_t                   node2_q;
  logic [DOMAIN_BITS-1:0]  mid1, mid2_q, xa;
  logic signed [VAL_W-1:0] new_a_q, old_a_q, new_m_q, old_m_q;
  logic                    win_lo, win_mid;
  logic [DOMAIN_BITS:0]    sum1;

  // stage 1: arm at the start level, issue the node read
  always_comb begin
    tok1_d = tok_i;
    if (tok_i.lvl == level_i) begin
      tok1_d.armed = 1'b1;
    end
  end

  assign raddr_o = tok_i.off;

  // stage 2: evaluate both lines at the low end (or query x) and the midpoint
  assign sum1 = {1'b0, tok1_q.lo} + {1'b0, tok1_q.hi};
  assign mid1 = sum1[DOMAIN_BITS:1];
  assign xa   = tok1_q.query ? tok1_q.qx : tok1_q.lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q <= '0;
      tok2_q <= '0;
      tok_o  <= '0;
    end else begin
      tok1_q <= tok1_d;
      tok2_q <= tok1_q;
      tok_o  <= tok3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node2_q <= rdata_i;
    mid2_q  <= mid1;
    new_a_q <= line_at(tok1_q.slope, tok1_q.icpt, xa);
    old_a_q <= line_at(rdata_i.slope, rdata_i.icpt, xa);
    new_m_q <= line_at(tok1_q.slope, tok1_q.icpt, mid1);
    old_m_q <= line_at(rdata_i.slope, rdata_i.icpt, mid1);
  end

  // stage 3: decide, write back, step to the child
  assign win_lo  = new_a_q < old_a_q;
  assign win_mid = new_m_q < old_m_q;

  always_comb begin
    tok3_d       = tok2_q;
    wr_o.we      = 1'b0;
    wr_o.addr    = tok2_q.off;
    wr_o.data    = '{used: 1'b1, slope: tok2_q.slope, icpt: tok2_q.icpt};
    if (tok2_q.valid && tok2_q.armed) begin
      if (tok2_q.query) begin
        if (node2_q.used) begin
          if (!tok2_q.found || (old_a_q < tok2_q.best)) begin
            tok3_d.best = old_a_q;
          end
          tok3_d.found = 1'b1;
        end
        if (tok2_q.lo < tok2_q.hi) begin
          if (tok2_q.qx <= mid2_q) begin
            tok3_d.off = tok2_q.off << 1;
            tok3_d.hi  = mid2_q;
          end else begin
            tok3_d.off = (tok2_q.off << 1) | DOMAIN_BITS'(1);
            tok3_d.lo  = mid2_q + DOMAIN_BITS'(1);
          end
        end else begin
          tok3_d.armed = 1'b0;
        end
      end else if (!node2_q.used) begin
        wr_o.we      = 1'b1;
        tok3_d.armed = 1'b0;
      end else begin
        if (win_mid) begin
          wr_o.we      = 1'b1;
          tok3_d.slope = node2_q.slope;
          tok3_d.icpt  = node2_q.icpt;
        end
        if (tok2_q.lo >= tok2_q.hi) begin
          tok3_d.armed = 1'b0;
        end else if (win_lo != win_mid) begin
          tok3_d.off = tok2_q.off << 1;
          tok3_d.hi  = mid2_q;
        end else begin
          tok3_d.off = (tok2_q.off << 1) | DOMAIN_BITS'(1);
          tok3_d.lo  = mid2_q + DOMAIN_BITS'(1);
        end
      end
    end
  end

endmodule

// File: rtl/lichao_min_line_store_core.sv
// ----------------------------------------------------------------------------
// lichao_min_line_store_core
// li chao tree holding lines for minimum queries over 0 .. 2^DOMAIN_BITS-1
// ----------------------------------------------------------------------------
// The tree is a row of DOMAIN_BITS+1 cells, one per level, each owning the
// memory of its level's nodes. Work moves down the row as a token, passing
// each cell's node read, line evaluation, and compare and write back. A
// query's result is valid when the input is ready again. A segment insert
// walks its decomposition; its canonical nodes sit in disjoint subtrees and
// enter the row one after another, followed by a closing token. One item is
// in the tree at a time; an insert is taken while a query result still
// waits at the output, a query waits until that result is taken. After
// reset a clearing pass zeroes the node used bits before the first item is
// taken.
module lichao_min_line_store_core
  import lms_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // slope[31:0], intercept[79:32], seg_low[89:80], seg_high[99:90],
  // query_x[109:100], zero pad[111:110]
  input  logic [111:0] s_axis_tdata_i,
  // kind[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // min_value[60:0], zero pad[63:61]
  output logic [63:0]  m_axis_tdata_o,
  // no_line[0]
  output logic         m_axis_tuser_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SEG   = 5'b00100,
    ST_QWAIT = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic [DOMAIN_BITS-1:0]  clr_q, clr_d;
  logic signed [31:0]      k_q, k_d;
  logic signed [47:0]      b_q, b_d;
  logic [DOMAIN_BITS-1:0]  qx_q, qx_d;
  logic                    miss_q, miss_d;
  logic [ARG_W-1:0]        l_q, l_d, r_q, r_d;
  tok_t                    iss_q, iss_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [60:0]      out_val_q, out_val_d;
  logic                    out_none_q, out_none_d;

  tok_t                    tok [LEVELS+1];
  logic                    accept;
  logic [ARG_W-1:0]        sl_e, sh_e, qx_e, sh_c;
  logic [DOMAIN_BITS:0]    seg_node;
  tok_t                    base_tok, seg_tok;
  tok_t                    tail_tok;

  // input field views
  logic signed [31:0]      in_slope;
  logic signed [47:0]      in_icpt;
  logic [9:0]              in_sl, in_sh, in_qx;

  assign in_slope = s_axis_tdata_i[31:0];
  assign in_icpt  = s_axis_tdata_i[79:32];
  assign in_sl    = s_axis_tdata_i[89:80];
  assign in_sh    = s_axis_tdata_i[99:90];
  assign in_qx    = s_axis_tdata_i[109:100];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign sl_e = ARG_W'(in_sl);
  assign sh_e = ARG_W'(in_sh);
  assign qx_e = ARG_W'(in_qx);
  assign sh_c = (sh_e > ARG_W'(DOMAIN_MAX)) ? ARG_W'(DOMAIN_MAX) : sh_e;

  // canonical node of the segment walk: heap index to level, offset, range
  function automatic tok_t node_tok(input logic [DOMAIN_BITS:0] idx,
                                    input tok_t base);
    tok_t                   t;
    logic [LVL_W-1:0]       lv;
    logic [DOMAIN_BITS:0]   off, span;
    t  = base;
    lv = '0;
    for (int d = 0; d <= DOMAIN_BITS; d++) begin
      if (idx[d]) begin
        lv = LVL_W'(d);
      end
    end
    off   = idx ^ ((DOMAIN_BITS+1)'(1) << lv);
    span  = (DOMAIN_BITS+1)'(DOMAIN_BITS) - (DOMAIN_BITS+1)'(lv);
    t.lvl = lv;
    t.off = off[DOMAIN_BITS-1:0];
    t.lo  = DOMAIN_BITS'(off << span);
    t.hi  = DOMAIN_BITS'(off << span) | DOMAIN_BITS'(((DOMAIN_BITS+1)'(1) << span) - 1'b1);
    return t;
  endfunction

  always_comb begin
    base_tok       = '0;
    base_tok.valid = 1'b1;
    base_tok.hi    = DOMAIN_MAX;
    base_tok.slope = k_q;
    base_tok.icpt  = b_q;
    tail_tok       = base_tok;
    tail_tok.tail  = 1'b1;
    tail_tok.lvl   = NO_LVL;
  end

  // segment step: take an odd left end, then an odd right end, else go up
  always_comb begin
    seg_node = l_q[DOMAIN_BITS:0];
    if (!l_q[0] && r_q[0]) begin
      seg_node = (DOMAIN_BITS+1)'(r_q - 1'b1);
    end
    seg_tok = node_tok(seg_node, base_tok);
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    k_d     = k_q;
    b_d     = b_q;
    qx_d    = qx_q;
    miss_d  = miss_q;
    l_d     = l_q;
    r_d     = r_q;
    iss_d   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == DOMAIN_MAX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          k_d = in_slope;
          b_d = in_icpt;
          case (kind_e'(s_axis_tuser_i))
            KIND_LINE: begin
              iss_d       = base_tok;
              iss_d.slope = in_slope;
              iss_d.icpt  = in_icpt;
              iss_d.tail  = 1'b1;
              state_d     = ST_DRAIN;
            end
            KIND_SEG: begin
              // empty or fully outside segments insert nothing
              if (!(sh_e < sl_e) && !(sl_e > ARG_W'(DOMAIN_MAX))) begin
                l_d     = sl_e + (ARG_W'(1) << DOMAIN_BITS);
                r_d     = sh_c + (ARG_W'(1) << DOMAIN_BITS) + ARG_W'(1);
                state_d = ST_SEG;
              end
            end
            KIND_QUERY: begin
              qx_d    = DOMAIN_BITS'(in_qx);
              miss_d  = qx_e > ARG_W'(DOMAIN_MAX);
              state_d = ST_QWAIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEG: begin
        if (l_q < r_q) begin
          if (l_q[0]) begin
            iss_d = seg_tok;
            l_d   = l_q + 1'b1;
          end else if (r_q[0]) begin
            iss_d = seg_tok;
            r_d   = r_q - 1'b1;
          end else begin
            l_d = l_q >> 1;
            r_d = r_q >> 1;
          end
        end else begin
          iss_d   = tail_tok;
          state_d = ST_DRAIN;
        end
      end
      ST_QWAIT: begin
        // the result slot must be free before the query goes in
        if (!out_valid_q) begin
          iss_d       = tail_tok;
          iss_d.query = 1'b1;
          iss_d.qx    = qx_q;
          iss_d.lvl   = miss_q ? NO_LVL : '0;
          state_d     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (tok[LEVELS].valid && tok[LEVELS].tail) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_none_d  = out_none_q;
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (tok[LEVELS].valid && tok[LEVELS].tail && tok[LEVELS].query) begin
      out_valid_d = 1'b1;
      out_val_d   = tok[LEVELS].found ? 61'(tok[LEVELS].best) : EMPTY_VALUE;
      out_none_d  = !tok[LEVELS].found;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      iss_q       <= iss_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    b_q        <= b_d;
    qx_q       <= qx_d;
    miss_q     <= miss_d;
    l_q        <= l_d;
    r_q        <= r_d;
    out_val_q  <= out_val_d;
    out_none_q <= out_none_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_val_q};
  assign m_axis_tuser_o  = out_none_q;

  assign tok[0] = iss_q;

  // one cell and one node memory per level
  for (genvar g = 0; g < LEVELS; g++) begin : g_level
    localparam int unsigned DEPTH = 1 << g;
    localparam int unsigned AW    = (g > 0) ? g : 1;

    logic [DOMAIN_BITS-1:0] raddr;
    node_t                  rdata;
    ram_wr_t                wr;
    logic                   we;
    logic [AW-1:0]          waddr, raddr_l;
    node_t                  wdata;
    logic [NODE_W-1:0]      rbits;

    lms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .level_i (LVL_W'(g)),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .raddr_o (raddr),
      .rdata_i (rdata),
      .wr_o    (wr)
    );

    // the clearing pass owns the write port until it is done
    always_comb begin
      if (state_q == ST_CLEAR) begin
        we    = 1'b1;
        waddr = (g > 0) ? AW'(clr_q) : '0;
        wdata = '0;
      end else begin
        we    = wr.we;
        waddr = AW'(wr.addr);
        wdata = wr.data;
      end
    end

    assign raddr_l = AW'(raddr);
    assign rdata   = node_t'(rbits);

    lms_ram #(
      .WIDTH (NODE_W),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .raddr_i (raddr_l),
      .rdata_o (rbits)
    );
  end

endmodule
